// ===== hw/rtl/index_free_list_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the index free list allocator
// Implication checks on a clock with a synchronous active high reset.
// ---------------------------------------------------------------------------
`ifndef INDEX_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define INDEX_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define IFL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication
`define IFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ===== hw/rtl/ifl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ifl_pkg
// Types, widths and codes shared by the free list allocator files.
// ---------------------------------------------------------------------------
package ifl_pkg;

   // pool geometry
   localparam int POOL_DEPTH = 1024;
   localparam int PTR_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   // field widths
   localparam int ACTION_W  = 2;
   localparam int FIDX_W    = 10;
   localparam int STATUS_W  = 2;
   localparam int SIDX_W    = 10;
   localparam int HANDLE_W  = 48;
   localparam int SCOUNT_W  = 11;
   localparam int STRIDE_W  = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 48;
   localparam int OFF_W     = STRIDE_W + PTR_W;

   // register reset values
   localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RST    = SCOUNT_W'(1024);
   localparam logic [STRIDE_W-1:0] HANDLE_STRIDE_RST = STRIDE_W'(32);

   typedef enum logic [ACTION_W-1:0] {
      ACT_REBUILD = 2'd0,
      ACT_ALLOC   = 2'd1,
      ACT_FREE    = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOT_COUNT    = 2'd0,
      CSR_HANDLE_STRIDE = 2'd1,
      CSR_CPU_BASE      = 2'd2,
      CSR_GPU_BASE      = 2'd3
   } csr_index_type;

   // slot count clamped to the pool depth
   function automatic logic [CNT_W-1:0] eff_count(input logic [SCOUNT_W-1:0] cnt);
      if (32'(cnt) > POOL_DEPTH) begin
         return CNT_W'(POOL_DEPTH);
      end
      return CNT_W'(cnt);
   endfunction

endpackage

// ===== hw/rtl/ifl_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ifl_req_if / ifl_rsp_if
// Valid/ready channels for allocator requests and results.
// ---------------------------------------------------------------------------
interface ifl_req_if;
   logic                          valid;
   logic                          ready;
   logic [ifl_pkg::ACTION_W-1:0]  action;
   logic [ifl_pkg::FIDX_W-1:0]    free_index;

   modport source (output valid, output action, output free_index, input ready);
   modport sink   (input valid, input action, input free_index, output ready);
endinterface

interface ifl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ifl_pkg::STATUS_W-1:0]  status;
   logic [ifl_pkg::SIDX_W-1:0]    slot_index;
   logic [ifl_pkg::HANDLE_W-1:0]  cpu_handle;
   logic [ifl_pkg::HANDLE_W-1:0]  gpu_handle;

   modport source (output valid, output status, output slot_index,
                   output cpu_handle, output gpu_handle, input ready);
   modport sink   (input valid, input status, input slot_index,
                   input cpu_handle, input gpu_handle, output ready);
endinterface

// ===== hw/rtl/index_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// index_free_list_allocator
// LIFO free list of slot indices held in a link memory, with handle math.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_if    in    valid/ready    action, free_index
//  rsp_if    out   valid/ready    status, slot_index, cpu_handle, gpu_handle
//  csr_*     in    write enable   csr_index, csr_wdata
//
//  Allocate, free and unused codes: link memory read at accept, head update
//  and result register in S_DONE, once the result register is free.
//  Rebuild: all POOL_DEPTH link entries rewritten, one link entry written per cycle.
//  After reset the same sweep runs over all POOL_DEPTH entries; no request is
//  taken until it ends.
//  A request is taken while an earlier result waits; the finishing cycle
//  stalls until the result register frees up.
// ---------------------------------------------------------------------------
module index_free_list_allocator (
   input  logic                            clock,
   input  logic                            reset,
   ifl_req_if.sink                         req_if,
   ifl_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [ifl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ifl_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import ifl_pkg::*;

   `include "index_free_list_allocator_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_DONE  = 3'b010,
      S_SWEEP = 3'b100
   } state_type;

   // configuration registers
   logic [SCOUNT_W-1:0] slot_count_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [HANDLE_W-1:0] cpu_base_ff;
   logic [HANDLE_W-1:0] gpu_base_ff;

   // control and list state
   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    sweep_cnt_ff;
   logic [CNT_W-1:0]    sweep_n_ff;
   logic                sweep_reply_ff;
   logic [PTR_W-1:0]    head_ff;
   logic                head_valid_ff;

   // request held for the finishing cycle
   logic [ACTION_W-1:0] act_ff;
   logic [FIDX_W-1:0]   fidx_ff;
   logic [OFF_W-1:0]    off_ff;

   // link memory: valid bit on top, link below
   logic [PTR_W:0]      link_mem [POOL_DEPTH];
   logic [PTR_W:0]      rd_data_ff;
   logic                mem_we;
   logic [PTR_W-1:0]    mem_addr;
   logic [PTR_W:0]      mem_wdata;

   // result register
   logic                rsp_valid_ff;
   status_type          status_ff;
   logic [SIDX_W-1:0]   sidx_ff;
   logic [HANDLE_W-1:0] cpu_ff;
   logic [HANDLE_W-1:0] gpu_ff;
   status_type          status_in;
   logic [SIDX_W-1:0]   sidx_in;
   logic [HANDLE_W-1:0] cpu_in;
   logic [HANDLE_W-1:0] gpu_in;

   logic                req_fire;
   logic                out_free;
   logic                done_fire;
   logic                sweep_last;
   logic                free_ok;
   logic [CNT_W-1:0]    cur_count;
   logic [CNT_W-1:0]    sweep_next;
   logic [HANDLE_W-1:0] off_ext;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign done_fire    = (state_ff == S_DONE) && out_free;
   assign sweep_last   = (32'(sweep_cnt_ff) == POOL_DEPTH - 1);
   assign sweep_next   = CNT_W'(sweep_cnt_ff) + CNT_W'(1);
   assign cur_count    = eff_count(slot_count_ff);
   assign free_ok      = (32'(fidx_ff) < 32'(cur_count));
   assign off_ext      = HANDLE_W'(off_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RST;
         stride_ff     <= HANDLE_STRIDE_RST;
         cpu_base_ff   <= '0;
         gpu_base_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLOT_COUNT:    slot_count_ff <= csr_wdata[SCOUNT_W-1:0];
            CSR_HANDLE_STRIDE: stride_ff     <= csr_wdata[STRIDE_W-1:0];
            CSR_CPU_BASE:      cpu_base_ff   <= csr_wdata[HANDLE_W-1:0];
            CSR_GPU_BASE:      gpu_base_ff   <= csr_wdata[HANDLE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (action_type'(req_if.action) == ACT_REBUILD) ? S_SWEEP : S_DONE;
            end
         end
         S_SWEEP: begin
            if (sweep_last) begin
               state_in = sweep_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory write port: sweep fill or free push
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = sweep_cnt_ff;
      mem_wdata = {(sweep_next < sweep_n_ff), sweep_next[PTR_W-1:0]};
      if (state_ff == S_SWEEP) begin
         mem_we = 1'b1;
      end else if (done_fire && action_type'(act_ff) == ACT_FREE && free_ok) begin
         mem_we    = 1'b1;
         mem_addr  = PTR_W'(fidx_ff);
         mem_wdata = {head_valid_ff, head_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_addr] <= mem_wdata;
      end
      // head link is fetched as the request is taken
      if (req_fire) begin
         rd_data_ff <= link_mem[head_ff];
      end
   end

   // request capture and stride product
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req_if.action;
         fidx_ff <= req_if.free_index;
         off_ff  <= OFF_W'(stride_ff) * OFF_W'(head_ff);
      end
   end

   // control state, sweep and list head
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         sweep_cnt_ff   <= '0;
         sweep_n_ff     <= eff_count(SLOT_COUNT_RST);
         sweep_reply_ff <= 1'b0;
         head_ff        <= '0;
         head_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            sweep_cnt_ff   <= '0;
            sweep_n_ff     <= cur_count;
            sweep_reply_ff <= 1'b1;
         end else if (state_ff == S_SWEEP) begin
            sweep_cnt_ff <= sweep_cnt_ff + PTR_W'(1);
            if (sweep_last) begin
               head_ff       <= '0;
               head_valid_ff <= (sweep_n_ff != '0);
            end
         end
         // pop or push on the finishing cycle
         if (done_fire) begin
            if (action_type'(act_ff) == ACT_ALLOC && head_valid_ff) begin
               head_ff       <= rd_data_ff[PTR_W-1:0];
               head_valid_ff <= rd_data_ff[PTR_W];
            end else if (action_type'(act_ff) == ACT_FREE && free_ok) begin
               head_ff       <= PTR_W'(fidx_ff);
               head_valid_ff <= 1'b1;
            end
         end
      end
   end

   // result fields of the finishing request
   always_comb begin
      status_in = ST_OK;
      sidx_in   = '0;
      cpu_in    = '0;
      gpu_in    = '0;
      unique case (action_type'(act_ff))
         ACT_ALLOC: begin
            if (head_valid_ff) begin
               sidx_in = SIDX_W'(head_ff);
               cpu_in  = cpu_base_ff + off_ext;
               gpu_in  = gpu_base_ff + off_ext;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         ACT_FREE: begin
            if (!free_ok) begin
               status_in = ST_INVALID;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         status_ff <= status_in;
         sidx_ff   <= sidx_in;
         cpu_ff    <= cpu_in;
         gpu_ff    <= gpu_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.slot_index = sidx_ff;
   assign rsp_if.cpu_handle = cpu_ff;
   assign rsp_if.gpu_handle = gpu_ff;

   // checks
   `IFL_ASSERT_NOW(a_no_take_in_sweep, clock, reset, state_ff == S_SWEEP, !req_if.ready)
   `IFL_ASSERT_NEXT(a_done_to_idle, clock, reset, done_fire, state_ff == S_IDLE && rsp_valid_ff)
   `IFL_ASSERT_NOW(a_mem_we_states, clock, reset, mem_we, state_ff == S_SWEEP || done_fire)
   `IFL_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff && status_ff != ST_OK, sidx_ff == '0 && cpu_ff == '0 && gpu_ff == '0)

endmodule
